// File: src/echo_envelope_decimator_assert.svh
// Assertion macros for the RTL files; only eed_fifo.sv includes them.
`ifndef ECHO_ENVELOPE_DECIMATOR_ASSERT_SVH
`define ECHO_ENVELOPE_DECIMATOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset
`define EED_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset
`define EED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EED_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define EED_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/eed_pkg.sv
`default_nettype none

package eed_pkg;

  // Field widths
  localparam int SAMPLE_W    = 12;
  localparam int CHAR_W      = 7;
  localparam int DECAY_SHIFT = 4;

  // Transfer queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  // Base64 alphabet anchors
  localparam logic [CHAR_W-1:0] B64_UPPER = 7'h41;  // 'A'
  localparam logic [CHAR_W-1:0] B64_LOWER = 7'h61;  // 'a'
  localparam logic [CHAR_W-1:0] B64_DIGIT = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] B64_PLUS  = 7'h2b;  // '+'
  localparam logic [CHAR_W-1:0] B64_SLASH = 7'h2f;  // '/'

  // Queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } eed_q_stat_t;

  // Six-bit value to its base64 character
  function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] idx);
    logic [CHAR_W-1:0] c;
    c = B64_SLASH;
    if (idx inside {[6'd0:6'd25]}) begin
      c = B64_UPPER + CHAR_W'(idx);
    end else if (idx inside {[6'd26:6'd51]}) begin
      c = B64_LOWER + CHAR_W'(idx - 6'd26);
    end else if (idx inside {[6'd52:6'd61]}) begin
      c = B64_DIGIT + CHAR_W'(idx - 6'd52);
    end else if (idx == 6'd62) begin
      c = B64_PLUS;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/echo_envelope_decimator.sv
// Throughput: one sample per cycle while full is low; one result per AVG_LEN samples.
// Path: the sample that completes its block is written into the queue on its transfer edge,
//   then passes the multiply stage and the result register before it is on the out_ ports.
// full rises only when the 4-entry block queue is full under a stalled result side.
// Reset: synchronous, active low; clears envelope, block sum, phase, mean level
//   and all valid state. No clearing pass.
`default_nettype none

module echo_envelope_decimator import eed_pkg::*; #(
  parameter int AVG_LEN   = 6,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // sample channel
  input  wire logic                push,
  output logic                     full,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic                in_start_of_capture,
  // result channel
  output logic                     empty,
  input  wire logic                pop,
  output logic [SAMPLE_W-1:0]      out_envelope,
  output logic [CHAR_W-1:0]        out_char_high,
  output logic [CHAR_W-1:0]        out_char_low,
  // mean level write
  input  wire logic                valid,
  output logic                     ready,
  input  wire logic [SAMPLE_W-1:0] cfg_mean_level
);

  localparam int TW = SAMPLE_W + $clog2(AVG_LEN);

  eed_q_stat_t   q_stat;
  logic          in_take, q_push, q_pop;
  logic [TW-1:0] q_wdata, q_rdata;

  assign ready   = 1'b1;
  assign full    = q_stat.full;
  assign in_take = push && !q_stat.full;

  eed_front #(
    .AVG_LEN   (AVG_LEN),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (valid),
    .cfg_data  (cfg_mean_level),
    .in_take   (in_take),
    .in_sample (in_sample),
    .in_start  (in_start_of_capture),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  eed_fifo #(
    .DW (TW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  eed_back #(
    .AVG_LEN (AVG_LEN)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_stat.empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_pop       (pop),
    .out_empty     (empty),
    .out_envelope  (out_envelope),
    .out_char_high (out_char_high),
    .out_char_low  (out_char_low)
  );

endmodule

`default_nettype wire

// File: src/eed_front.sv
`default_nettype none

// Front: mean removal, peak envelope and block accumulation.
module eed_front import eed_pkg::*; #(
  parameter int AVG_LEN   = 6,
  parameter int FRAC_BITS = 8,
  localparam int TW       = SAMPLE_W + $clog2(AVG_LEN)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [SAMPLE_W-1:0] cfg_data,
  input  wire logic                in_take,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic                in_start,
  output logic                     q_push,
  output logic [TW-1:0]            q_data
);

  localparam int EW  = SAMPLE_W + FRAC_BITS;
  localparam int PHW = $clog2(AVG_LEN);
  localparam int SW  = EW + PHW;

  logic [SAMPLE_W-1:0] mean_r;
  logic [EW-1:0]       env_r, env_nxt, env_cur, x_fix;
  logic [SW-1:0]       acc_r, acc_nxt, acc_base;
  logic [PHW-1:0]      phase_r, phase_nxt, phase_cur;
  logic [SAMPLE_W-1:0] x;
  logic                last;

  // Mean level register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
    end else if (cfg_we) begin
      mean_r <= cfg_data;
    end
  end

  // Clamp at zero, scale, attack or decay
  always_comb begin
    x         = (in_sample > mean_r) ? (in_sample - mean_r) : '0;
    x_fix     = EW'(x) << FRAC_BITS;
    env_cur   = in_start ? '0 : env_r;
    phase_cur = in_start ? '0 : phase_r;
    env_nxt   = (x_fix > env_cur) ? x_fix : (env_cur - (env_cur >> DECAY_SHIFT));
    acc_base  = (phase_cur == '0) ? '0 : acc_r;
    acc_nxt   = acc_base + SW'(env_nxt);
    last      = (phase_cur == PHW'(AVG_LEN - 1));
    phase_nxt = last ? '0 : (phase_cur + 1'b1);
  end

  // Capture state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r   <= '0;
      acc_r   <= '0;
      phase_r <= '0;
    end else if (in_take) begin
      env_r   <= env_nxt;
      acc_r   <= acc_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Completed block: drop fraction bits and hand over
  assign q_push = in_take && last;
  assign q_data = acc_nxt[SW-1:FRAC_BITS];

endmodule

`default_nettype wire

// File: src/eed_fifo.sv
`default_nettype none

`include "echo_envelope_decimator_assert.svh"

// Short queue of block sums between front and back.
module eed_fifo import eed_pkg::*; #(
  parameter int DW = 15
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          pop,
  output logic [DW-1:0]      rdata,
  output eed_q_stat_t        stat
);

  logic [DW-1:0]   mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_CW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign stat.full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rp_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + Q_CW'(do_push) - Q_CW'(do_pop);
    end
  end

  `EED_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= Q_CW'(Q_DEPTH))
  `EED_ASSERT_SAME(a_ptr_gap, clk, rst_n, 1'b1, Q_AW'(wp_r - rp_r) == Q_AW'(cnt_r))
  `EED_ASSERT_NEXT(a_cnt_up, clk, rst_n, do_push && !do_pop, cnt_r == $past(cnt_r) + 1'b1)
  `EED_ASSERT_NEXT(a_cnt_down, clk, rst_n, do_pop && !do_push, cnt_r == $past(cnt_r) - 1'b1)

endmodule

`default_nettype wire

// File: src/eed_back.sv
`default_nettype none

// Back: divide block sum by AVG_LEN, encode, hold result.
module eed_back import eed_pkg::*; #(
  parameter int AVG_LEN = 6,
  localparam int TW     = SAMPLE_W + $clog2(AVG_LEN)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire logic [TW-1:0] q_data,
  output logic               q_pop,
  input  wire logic          out_pop,
  output logic               out_empty,
  output logic [SAMPLE_W-1:0] out_envelope,
  output logic [CHAR_W-1:0]  out_char_high,
  output logic [CHAR_W-1:0]  out_char_low
);

  // Reciprocal: floor(t / AVG_LEN) == (t * RECIP) >> K for every t below 2**TW
  localparam int K  = TW + $clog2(AVG_LEN);
  localparam int MW = TW + 1;
  localparam int PW = TW + MW;
  localparam longint RECIP_L = ((64'sd1 <<< K) + AVG_LEN - 1) / AVG_LEN;
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

  logic [PW-1:0]       prod_r;
  logic                v1_r, ov_r;
  logic                s1_rdy, out_rdy;
  logic [SAMPLE_W-1:0] env;
  logic [SAMPLE_W-1:0] env_r;
  logic [CHAR_W-1:0]   ch_hi_r, ch_lo_r;

  // Stall chain from the result side
  assign out_rdy = !ov_r || out_pop;
  assign s1_rdy  = !v1_r || out_rdy;
  assign q_pop   = !q_empty && s1_rdy;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (s1_rdy) begin
      v1_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_r <= PW'(q_data) * PW'(RECIP);
    end
  end

  assign env = prod_r[K +: SAMPLE_W];

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_rdy) begin
      ov_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && v1_r) begin
      env_r   <= env;
      ch_hi_r <= b64_char(env[11:6]);
      ch_lo_r <= b64_char(env[5:0]);
    end
  end

  assign out_empty     = !ov_r;
  assign out_envelope  = env_r;
  assign out_char_high = ch_hi_r;
  assign out_char_low  = ch_lo_r;

endmodule

`default_nettype wire
